// ===== design/ptcl_pkg.sv =====
`default_nettype none
package ptcl_pkg;

   localparam int LEVELS          = 16;
   localparam int TILES_PER_LEVEL = 256;
   localparam int LEVEL_W         = 4;
   localparam int TILE_W          = 8;
   localparam int SLOT_W          = LEVEL_W + TILE_W;
   localparam int STAMP_W         = 32;

   typedef enum logic [1:0] {
      OP_GET_LOAD = 2'd0,
      OP_GET_SHY  = 2'd1,
      OP_GEOM     = 2'd2,
      OP_UNUSED   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      STS_HIT         = 3'd0,
      STS_MISS_LOAD   = 3'd1,
      STS_SHY_MISS    = 3'd2,
      STS_GEOM_OK     = 3'd3,
      STS_GEOM_REJECT = 3'd4,
      STS_LEVEL_UNDEF = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      CSR_NUM_LEVELS   = 3'd0,
      CSR_TILE_WIDTH   = 3'd1,
      CSR_TILE_HEIGHT  = 3'd2,
      CSR_BYTES_PER_PX = 3'd3,
      CSR_MAX_RESIDENT = 3'd4
   } csr_reg_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOKUP,
      S_DIVIDE,
      S_MULTIPLY,
      S_CHECK,
      S_PROBE_RD,
      S_PROBE,
      S_SCAN,
      S_SCAN_TAIL,
      S_EVICT,
      S_INSTALL,
      S_SWEEP,
      S_COMMIT,
      S_FINISH
   } fsm_state_type;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic mul;
      logic check;
      logic probe_rd;
      logic probe;
      logic scan;
      logic evict;
      logic install;
      logic sweep;
      logic commit;
      logic clear;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   lk_final;
      logic   div_done;
      logic   chk_final;
      logic   hit;
      logic   need_evict;
      logic   scan_last;
      logic   sweep_last;
      logic   clear_last;
   } sts_type;

endpackage
`default_nettype wire

// ===== design/ptcl_div.sv =====
`default_nettype none
module ptcl_div
   import ptcl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [16:0] dividend,
   input  wire logic [10:0] divisor,
   output logic      [16:0] quotient,
   output logic      [9:0]  remainder,
   output logic             done
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [16:0] q_ff, q_in;
   logic [9:0]  r_ff, r_in;
   logic [10:0] d_ff, d_in;
   logic [10:0] shift;
   logic [10:0] diff;
   logic        ge;

   assign shift = {r_ff, q_ff[16]};
   assign ge    = (shift >= d_ff);
   assign diff  = shift - d_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         q_in    = dividend;
         r_in    = '0;
         d_in    = divisor;
      end else if (busy_ff) begin
         // one quotient bit per cycle, restoring
         r_in   = ge ? diff[9:0] : shift[9:0];
         q_in   = {q_ff[15:0], ge};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd16) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign quotient  = q_ff;
   assign remainder = r_ff;
   assign done      = done_ff;

endmodule
`default_nettype wire

// ===== design/ptcl_datapath.sv =====
`default_nettype none
module ptcl_datapath
   import ptcl_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   output sts_type                 sts,
   input  wire logic [1:0]         req_op,
   input  wire logic [4:0]         req_level,
   input  wire logic signed [16:0] req_px,
   input  wire logic signed [16:0] req_py,
   input  wire logic [15:0]        req_level_width,
   input  wire logic [15:0]        req_level_height,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [12:0]        csr_data,
   output logic [2:0]              rsp_status,
   output logic [3:0]              rsp_level_used,
   output logic [7:0]              rsp_tile_number,
   output logic [24:0]             rsp_byte_offset,
   output logic                    rsp_evict_valid,
   output logic [3:0]              rsp_evict_level,
   output logic [7:0]              rsp_evict_tile
);

   // configuration
   logic [4:0]  num_levels_ff;
   logic [10:0] tile_w_ff, tile_h_ff;
   logic [5:0]  bpp_ff;
   logic [12:0] max_res_ff;
   logic [4:0]  nl_wr;
   logic [10:0] tw_wr, th_wr;
   logic [5:0]  bpp_wr;
   logic [12:0] max_wr;

   // captured request
   op_type             op_ff;
   logic [4:0]         lvin_ff;
   logic signed [16:0] px_ff, py_ff;
   logic [15:0]        lw_ff, lh_ff;

   // geometry table
   logic [15:0] gw_ff [LEVELS];
   logic [15:0] gh_ff [LEVELS];
   logic [8:0]  gacross_ff [LEVELS];
   logic [8:0]  gtotal_ff [LEVELS];
   logic [8:0]  lvl_cnt_ff [LEVELS];

   // working registers
   logic [LEVEL_W-1:0] lv_ff;
   logic [8:0]         across_ff, total_ff;
   logic [33:0]        prod_ff;
   logic [20:0]        pixp_ff;
   logic [TILE_W-1:0]  tidx_ff;
   logic [19:0]        pix_ff;
   logic [24:0]        offset_ff;
   status_type         res_status_ff;
   logic               ev_valid_ff;
   logic [SLOT_W-1:0]  walk_ff, sd_addr_ff, best_addr_ff;
   logic               sv_ff, found_ff;
   logic [STAMP_W-1:0] best_stamp_ff;
   logic [STAMP_W-1:0] stamp_ff;
   logic [12:0]        total_res_ff;

   // memory
   logic [STAMP_W:0]   mem [LEVELS*TILES_PER_LEVEL];
   logic [STAMP_W:0]   rdata_ff;
   logic               mem_we, mem_re;
   logic [SLOT_W-1:0]  mem_waddr, mem_raddr;
   logic [STAMP_W:0]   mem_wdata;

   // combinational
   logic [4:0]         lv_full;
   logic [LEVEL_W-1:0] lv_sel, gidx, lvl_res;
   logic [15:0]        g_w, g_h;
   logic signed [17:0] px_ext, py_ext, wlim, hlim;
   logic [15:0]        x_cl, y_cl;
   logic               lk_final;
   status_type         lk_status;
   logic [16:0]        div_a_x, div_a_y;
   logic [16:0]        qx, qy;
   logic [9:0]         rx, ry;
   logic               dx_done, dy_done;
   logic [24:0]        tidx;
   logic               chk_final;
   status_type         chk_status;
   logic [25:0]        off_full;
   logic [SLOT_W-1:0]  slot;
   logic               hit;
   logic [STAMP_W-1:0] stamp_inc, stamp_nx;
   logic               cand;
   logic               result_tile;

   assign csr_ready = 1'b1;

   // saturate register writes into range
   always_comb begin
      nl_wr  = (csr_data[4:0] == 5'd0) ? 5'd1 :
               (csr_data[4:0] > 5'd16) ? 5'd16 : csr_data[4:0];
      tw_wr  = (csr_data[10:0] == 11'd0) ? 11'd1 :
               (csr_data[10:0] > 11'd1024) ? 11'd1024 : csr_data[10:0];
      th_wr  = tw_wr;
      bpp_wr = (csr_data[5:0] == 6'd0) ? 6'd1 :
               (csr_data[5:0] > 6'd32) ? 6'd32 : csr_data[5:0];
      max_wr = (csr_data > 13'd4096) ? 13'd4096 : csr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_levels_ff <= 5'd1;
         tile_w_ff     <= 11'd256;
         tile_h_ff     <= 11'd256;
         bpp_ff        <= 6'd1;
         max_res_ff    <= 13'd0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_NUM_LEVELS:   num_levels_ff <= nl_wr;
            CSR_TILE_WIDTH:   tile_w_ff     <= tw_wr;
            CSR_TILE_HEIGHT:  tile_h_ff     <= th_wr;
            CSR_BYTES_PER_PX: bpp_ff        <= bpp_wr;
            CSR_MAX_RESIDENT: max_res_ff    <= max_wr;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= op_type'(req_op);
         lvin_ff <= req_level;
         px_ff   <= req_px;
         py_ff   <= req_py;
         lw_ff   <= req_level_width;
         lh_ff   <= req_level_height;
      end
   end

   // lookup: clamp level and pixel
   always_comb begin
      lv_full = (lvin_ff < num_levels_ff) ? lvin_ff : num_levels_ff - 5'd1;
      lv_sel  = lv_full[LEVEL_W-1:0];
      gidx    = cmd.lookup ? lv_sel : sd_addr_ff[SLOT_W-1:TILE_W];
      g_w     = gw_ff[gidx];
      g_h     = gh_ff[gidx];
      px_ext  = {px_ff[16], px_ff};
      py_ext  = {py_ff[16], py_ff};
      wlim    = $signed({2'b00, g_w}) - 18'sd1;
      hlim    = $signed({2'b00, g_h}) - 18'sd1;
      x_cl    = (px_ext < 18'sd0) ? 16'd0 : (px_ext > wlim) ? wlim[15:0] : px_ext[15:0];
      y_cl    = (py_ext < 18'sd0) ? 16'd0 : (py_ext > hlim) ? hlim[15:0] : py_ext[15:0];
      lk_final  = 1'b0;
      lk_status = STS_HIT;
      lvl_res   = lv_sel;
      case (op_ff)
         OP_UNUSED: begin
            lk_final  = 1'b1;
            lk_status = STS_GEOM_REJECT;
            lvl_res   = '0;
         end
         OP_GEOM: begin
            lvl_res = lvin_ff[LEVEL_W-1:0];
            if (lvin_ff >= 5'(LEVELS) || lw_ff == 16'd0 || lh_ff == 16'd0) begin
               lk_final  = 1'b1;
               lk_status = STS_GEOM_REJECT;
            end
         end
         default: begin
            if (g_w == 16'd0 || g_h == 16'd0) begin
               lk_final  = 1'b1;
               lk_status = STS_LEVEL_UNDEF;
            end
         end
      endcase
      // tile counts round up on a geometry write
      if (op_ff == OP_GEOM) begin
         div_a_x = 17'(lw_ff) + 17'(tile_w_ff) - 17'd1;
         div_a_y = 17'(lh_ff) + 17'(tile_h_ff) - 17'd1;
      end else begin
         div_a_x = {1'b0, x_cl};
         div_a_y = {1'b0, y_cl};
      end
   end

   ptcl_div u_div_x (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.lookup),
      .dividend  (div_a_x),
      .divisor   (tile_w_ff),
      .quotient  (qx),
      .remainder (rx),
      .done      (dx_done)
   );

   ptcl_div u_div_y (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.lookup),
      .dividend  (div_a_y),
      .divisor   (tile_h_ff),
      .quotient  (qy),
      .remainder (ry),
      .done      (dy_done)
   );

   // check stage
   always_comb begin
      tidx       = 25'(prod_ff) + 25'(qx);
      chk_final  = 1'b0;
      chk_status = STS_HIT;
      if (op_ff == OP_GEOM) begin
         if (prod_ff > 34'(TILES_PER_LEVEL)) begin
            chk_final  = 1'b1;
            chk_status = STS_GEOM_REJECT;
         end
      end else if (tidx >= 25'(total_ff)) begin
         chk_final  = 1'b1;
         chk_status = STS_LEVEL_UNDEF;
      end
   end

   assign off_full  = 26'(pix_ff) * 26'(bpp_ff);
   assign slot      = {lv_ff, tidx_ff};
   assign hit       = rdata_ff[STAMP_W];
   assign stamp_inc = stamp_ff + 32'd1;
   assign stamp_nx  = (stamp_inc == 32'd0) ? 32'd1 : stamp_inc;

   assign cand = sv_ff && rdata_ff[STAMP_W] && (rdata_ff[STAMP_W-1:0] != 32'd0) &&
                 ({1'b0, sd_addr_ff[TILE_W-1:0]} < gtotal_ff[gidx]) &&
                 (!found_ff || rdata_ff[STAMP_W-1:0] < best_stamp_ff);

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         lv_ff         <= lvl_res;
         across_ff     <= gacross_ff[gidx];
         total_ff      <= gtotal_ff[gidx];
         res_status_ff <= lk_status;
      end
      if (cmd.mul) begin
         prod_ff <= 34'(qy) * ((op_ff == OP_GEOM) ? 34'(qx) : 34'(across_ff));
         pixp_ff <= 21'(ry) * 21'(tile_w_ff);
      end
      if (cmd.check) begin
         tidx_ff <= tidx[TILE_W-1:0];
         pix_ff  <= pixp_ff[19:0] + 20'(rx);
         if (chk_final) begin
            res_status_ff <= chk_status;
         end
      end
      if (cmd.probe_rd) begin
         offset_ff <= off_full[24:0];
      end
      if (cmd.probe) begin
         res_status_ff <= hit ? STS_HIT :
                          (op_ff == OP_GET_SHY) ? STS_SHY_MISS : STS_MISS_LOAD;
      end
      if (cmd.commit) begin
         res_status_ff <= STS_GEOM_OK;
      end
      if (cand) begin
         best_stamp_ff <= rdata_ff[STAMP_W-1:0];
         best_addr_ff  <= sd_addr_ff;
      end
      sd_addr_ff <= walk_ff;
   end

   // control state of the datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff      <= '0;
         sv_ff        <= 1'b0;
         found_ff     <= 1'b0;
         ev_valid_ff  <= 1'b0;
         stamp_ff     <= '0;
         total_res_ff <= '0;
         for (int i = 0; i < LEVELS; i++) begin
            gw_ff[i]      <= '0;
            gh_ff[i]      <= '0;
            gacross_ff[i] <= '0;
            gtotal_ff[i]  <= '0;
            lvl_cnt_ff[i] <= '0;
         end
      end else begin
         sv_ff <= cmd.scan;
         if (cmd.clear || cmd.sweep || cmd.scan) begin
            walk_ff <= walk_ff + 12'd1;
         end else if (cmd.check) begin
            walk_ff <= {lvin_ff[LEVEL_W-1:0], {TILE_W{1'b0}}};
         end else if (cmd.probe) begin
            walk_ff <= '0;
         end
         if (cmd.capture) begin
            ev_valid_ff <= 1'b0;
         end
         if (cmd.probe) begin
            found_ff <= 1'b0;
         end else if (cand) begin
            found_ff <= 1'b1;
         end
         if (((cmd.probe && hit) || cmd.install) && max_res_ff != 13'd0) begin
            stamp_ff <= stamp_nx;
         end
         if (cmd.evict && found_ff) begin
            ev_valid_ff  <= 1'b1;
            total_res_ff <= total_res_ff - 13'd1;
            lvl_cnt_ff[best_addr_ff[SLOT_W-1:TILE_W]] <=
               lvl_cnt_ff[best_addr_ff[SLOT_W-1:TILE_W]] - 9'd1;
         end else if (cmd.install) begin
            total_res_ff      <= total_res_ff + 13'd1;
            lvl_cnt_ff[lv_ff] <= lvl_cnt_ff[lv_ff] + 9'd1;
         end else if (cmd.commit) begin
            total_res_ff <= total_res_ff - 13'(lvl_cnt_ff[lvin_ff[LEVEL_W-1:0]]);
            lvl_cnt_ff[lvin_ff[LEVEL_W-1:0]] <= '0;
            gw_ff[lvin_ff[LEVEL_W-1:0]]      <= lw_ff;
            gh_ff[lvin_ff[LEVEL_W-1:0]]      <= lh_ff;
            gacross_ff[lvin_ff[LEVEL_W-1:0]] <= qx[8:0];
            gtotal_ff[lvin_ff[LEVEL_W-1:0]]  <= prod_ff[8:0];
         end
      end
   end

   // memory ports
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = walk_ff;
      mem_wdata = '0;
      if (cmd.clear || cmd.sweep) begin
         mem_we = 1'b1;
      end else if (cmd.probe) begin
         mem_we    = hit && (max_res_ff != 13'd0);
         mem_waddr = slot;
         mem_wdata = {1'b1, stamp_nx};
      end else if (cmd.evict) begin
         mem_we    = found_ff;
         mem_waddr = best_addr_ff;
      end else if (cmd.install) begin
         mem_we    = 1'b1;
         mem_waddr = slot;
         mem_wdata = {1'b1, (max_res_ff != 13'd0) ? stamp_nx : 32'd0};
      end
      mem_re    = cmd.probe_rd || cmd.scan;
      mem_raddr = cmd.scan ? walk_ff : slot;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   // result register
   assign result_tile = (res_status_ff == STS_HIT) || (res_status_ff == STS_MISS_LOAD) ||
                        (res_status_ff == STS_SHY_MISS);

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status      <= res_status_ff;
         rsp_level_used  <= lv_ff;
         rsp_tile_number <= result_tile ? tidx_ff : '0;
         rsp_byte_offset <= result_tile ? offset_ff : '0;
         if (res_status_ff == STS_MISS_LOAD && ev_valid_ff) begin
            rsp_evict_valid <= 1'b1;
            rsp_evict_level <= best_addr_ff[SLOT_W-1:TILE_W];
            rsp_evict_tile  <= best_addr_ff[TILE_W-1:0];
         end else begin
            rsp_evict_valid <= 1'b0;
            rsp_evict_level <= '0;
            rsp_evict_tile  <= '0;
         end
      end
   end

   always_comb begin
      sts.op         = op_ff;
      sts.lk_final   = lk_final;
      sts.div_done   = dx_done && dy_done;
      sts.chk_final  = chk_final;
      sts.hit        = hit;
      sts.need_evict = (max_res_ff != 13'd0) && (total_res_ff >= max_res_ff);
      sts.scan_last  = (walk_ff == {4'(num_levels_ff - 5'd1), {TILE_W{1'b1}}});
      sts.sweep_last = (walk_ff[TILE_W-1:0] == {TILE_W{1'b1}});
      sts.clear_last = (walk_ff == {SLOT_W{1'b1}});
   end

`ifndef ASSERT_OFF
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_res_ff <= 13'd4096)
      else $error("resident count above limit");

   a_install_count: assert property (@(posedge clock) disable iff (reset)
      cmd.install |=> total_res_ff == 13'($past(total_res_ff) + 13'd1))
      else $error("install did not count the tile");

   a_evict_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.evict && found_ff) |=> total_res_ff == 13'($past(total_res_ff) - 13'd1))
      else $error("eviction did not drop the tile");
`endif

endmodule
`default_nettype wire

// ===== design/ptcl_ctrl.sv =====
`default_nettype none
module ptcl_ctrl
   import ptcl_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   fsm_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_free;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:     if (sts.clear_last) state_in = S_IDLE;
         S_IDLE:      if (req_valid) state_in = S_LOOKUP;
         S_LOOKUP:    state_in = sts.lk_final ? S_FINISH : S_DIVIDE;
         S_DIVIDE:    if (sts.div_done) state_in = S_MULTIPLY;
         S_MULTIPLY:  state_in = S_CHECK;
         S_CHECK: begin
            if (sts.chk_final) begin
               state_in = S_FINISH;
            end else if (sts.op == OP_GEOM) begin
               state_in = S_SWEEP;
            end else begin
               state_in = S_PROBE_RD;
            end
         end
         S_PROBE_RD:  state_in = S_PROBE;
         S_PROBE: begin
            if (sts.hit || sts.op == OP_GET_SHY) begin
               state_in = S_FINISH;
            end else if (sts.need_evict) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_INSTALL;
            end
         end
         S_SCAN:      if (sts.scan_last) state_in = S_SCAN_TAIL;
         S_SCAN_TAIL: state_in = S_EVICT;
         S_EVICT:     state_in = S_INSTALL;
         S_INSTALL:   state_in = S_FINISH;
         S_SWEEP:     if (sts.sweep_last) state_in = S_COMMIT;
         S_COMMIT:    state_in = S_FINISH;
         S_FINISH:    if (rsp_free) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_CLEAR:    cmd.clear    = 1'b1;
         S_IDLE:     cmd.capture  = req_valid;
         S_LOOKUP:   cmd.lookup   = 1'b1;
         S_MULTIPLY: cmd.mul      = 1'b1;
         S_CHECK:    cmd.check    = 1'b1;
         S_PROBE_RD: cmd.probe_rd = 1'b1;
         S_PROBE:    cmd.probe    = 1'b1;
         S_SCAN:     cmd.scan     = 1'b1;
         S_EVICT:    cmd.evict    = 1'b1;
         S_INSTALL:  cmd.install  = 1'b1;
         S_SWEEP:    cmd.sweep    = 1'b1;
         S_COMMIT:   cmd.commit   = 1'b1;
         S_FINISH:   cmd.load_rsp = rsp_free;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_finish_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("finished request not presented");
`endif

endmodule
`default_nettype wire

// ===== design/pyramid_tile_cache_lru_core.sv =====
// Hit or shy miss: lookup, then the two 17-step dividers (pixel to tile column and row),
//   multiply, check, probe read and probe. Geometry write: the same front end, then a sweep
//   of the level (one tile slot cleared per cycle). A load that evicts first scans every slot
//   of the configured levels, one stamp read per cycle through the single memory read port.
// Throughput: one request at a time; the next is taken while a result waits.
// Reset: synchronous; afterwards a pass clears all 4096 tile slots with requests stalled.
`default_nettype none
module pyramid_tile_cache_lru_core
   import ptcl_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_op,
   input  wire logic [4:0]         req_level,
   input  wire logic signed [16:0] req_px,
   input  wire logic signed [16:0] req_py,
   input  wire logic [15:0]        req_level_width,
   input  wire logic [15:0]        req_level_height,
   // result channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [2:0]              rsp_status,
   output logic [3:0]              rsp_level_used,
   output logic [7:0]              rsp_tile_number,
   output logic [24:0]             rsp_byte_offset,
   output logic                    rsp_evict_valid,
   output logic [3:0]              rsp_evict_level,
   output logic [7:0]              rsp_evict_tile,
   // register writes
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [12:0]        csr_data
);

   cmd_type cmd;
   sts_type sts;

   // sequence: lookup, divide, multiply, check, then probe (scan on evict) or sweep
   ptcl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // hold geometry, residency memory, stamps and the result register
   ptcl_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_op           (req_op),
      .req_level        (req_level),
      .req_px           (req_px),
      .req_py           (req_py),
      .req_level_width  (req_level_width),
      .req_level_height (req_level_height),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_status       (rsp_status),
      .rsp_level_used   (rsp_level_used),
      .rsp_tile_number  (rsp_tile_number),
      .rsp_byte_offset  (rsp_byte_offset),
      .rsp_evict_valid  (rsp_evict_valid),
      .rsp_evict_level  (rsp_evict_level),
      .rsp_evict_tile   (rsp_evict_tile)
   );

endmodule
`default_nettype wire
